// ===== hdl/bfmm_pkg.sv =====
`timescale 1ns / 1ps
package bfmm_pkg;

    // Store capacity and the widths that follow from it.
    localparam int unsigned MAX_BLOBS = 8;
    localparam int unsigned CNT_W     = $clog2(MAX_BLOBS + 1);
    localparam int unsigned IDX_W     = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;

    // Field widths.
    localparam int unsigned COORD_W = 11;
    localparam int unsigned COLOR_W = 4;
    localparam int unsigned DIST_W  = 8;
    localparam int unsigned SQ_W    = 2 * COORD_W;
    localparam int unsigned SUM_W   = SQ_W + 1;
    localparam int unsigned THR_W   = 2 * (DIST_W + 1) - 1;

    // Configuration registers.
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0] REG_MAX_MATCH  = 1'b0;
    localparam logic [0:0] REG_MIN_MOTION = 1'b1;
    localparam logic [DIST_W-1:0] MAX_MATCH_RESET  = 8'd10;
    localparam logic [DIST_W-1:0] MIN_MOTION_RESET = 8'd1;

    typedef struct packed {
        logic               has_blob;
        logic [COORD_W-1:0] blob_x;
        logic [COORD_W-1:0] blob_y;
        logic [COLOR_W-1:0] blob_color;
        logic               frame_last;
    } t_in_beat;

    typedef struct packed {
        logic               is_motion;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic               overflow;
        logic               last_of_frame;
    } t_out_beat;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_blob;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             bank_sel;
        logic [IDX_W-1:0] prev_idx;
        logic [IDX_W-1:0] cur_idx;
    } t_store_ctl;

    typedef struct packed {
        logic en;
        logic acc;
    } t_mac_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_THR_MAX,
        S_THR_MIN,
        S_START,
        S_SCAN,
        S_READ,
        S_SQY,
        S_CHECK,
        S_FINISH
    } t_state;

endpackage

// ===== hdl/blob_frame_motion_matcher_unit.sv =====
`timescale 1ns / 1ps
// Blob frame motion matcher.
// Input channel (i_in_valid / o_in_ready / i_in_data): one blob or a bare
// frame end per beat. A beat without frame_last is accepted whenever idle.
// A beat with frame_last starts the matching pass, and o_in_ready stays low
// until the pass has handed its last result to the output register.
// The pass squares both thresholds plus one on the shared squarer, then visits
// each pair of a previous and a current blob: scan and read when the colors
// differ, scan, read, add dy squared and check when they agree, with one wrap
// scan per previous blob, then a final scan and a closing state.
// The squared distance is compared with these squares, which gives the same
// answer as comparing its truncated root with the thresholds. Output channel
// (o_out_valid / i_out_ready / o_out_data): one beat per motion, or one end
// marker; the final beat of a frame has last_of_frame set. One record is held
// back so that the final one can be marked; a stalled receiver holds the pass
// in place without losing anything. Configuration goes over the APB port
// (register 0 at 0x0, register 1 at 0x4), written by the user only while idle;
// the block itself does not enforce this. Reset empties both frames, clears
// the overflow flag and the output, and restores the thresholds to 10 and 1.
module blob_frame_motion_matcher_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bfmm_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bfmm_pkg::t_out_beat           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfmm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bfmm_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [DIST_W-1:0] r_max;
    logic [DIST_W-1:0] r_min;
    logic [THR_W-1:0]  r_thr_max;
    logic [THR_W-1:0]  r_thr_min;
    logic [CNT_W-1:0]  r_cur_count;
    logic [CNT_W-1:0]  r_prev_count;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic              r_ovf;
    logic              r_bank_sel;
    logic              r_pend_valid;
    t_out_beat         r_pend;
    logic              r_out_valid;
    t_out_beat         r_out_data;
    t_out_beat         n_out_data;

    t_store_ctl         store_ctl;
    t_blob              wr_blob;
    t_blob              prev_blob;
    t_blob              cur_blob;
    t_mac_ctl           mac_ctl;
    logic [COORD_W-1:0] mac_operand;
    logic [SUM_W-1:0]   mac_sum;

    logic               in_fire;
    logic               cfg_wr;
    logic               store_wr;
    logic               out_free;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               color_eq;
    logic               motion;
    logic               chk_go;
    logic               scan_done;
    logic               scan_wrap;

    // Strobes from the sequencer.
    logic cap_thr_max;
    logic cap_thr_min;
    logic do_wrap;
    logic adv_j;
    logic load_pend;
    logic push_mid;
    logic finish_go;

    // Handshakes.
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign out_free   = !r_out_valid || i_out_ready;
    assign store_wr   = in_fire && i_in_data.has_blob && (r_cur_count < CNT_W'(MAX_BLOBS));

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            REG_MAX_MATCH:  prdata = {24'd0, r_max};
            REG_MIN_MOTION: prdata = {24'd0, r_min};
            default:        prdata = 32'd0;
        endcase
    end

    // Blob store.
    assign wr_blob.color       = i_in_data.blob_color;
    assign wr_blob.y           = i_in_data.blob_y;
    assign wr_blob.x           = i_in_data.blob_x;
    assign store_ctl.wr_en     = store_wr;
    assign store_ctl.wr_idx    = r_cur_count[IDX_W-1:0];
    assign store_ctl.bank_sel  = r_bank_sel;
    assign store_ctl.prev_idx  = r_i[IDX_W-1:0];
    assign store_ctl.cur_idx   = r_j[IDX_W-1:0];

    bfmm_store u_store (
        .i_clk       (i_clk),
        .i_ctl       (store_ctl),
        .i_wr_blob   (wr_blob),
        .o_prev_blob (prev_blob),
        .o_cur_blob  (cur_blob)
    );

    bfmm_sq_acc u_sq_acc (
        .i_clk     (i_clk),
        .i_ctl     (mac_ctl),
        .i_operand (mac_operand),
        .o_sum     (mac_sum)
    );

    // Pair evaluation on the registered store outputs.
    assign dx = (prev_blob.x > cur_blob.x) ? (prev_blob.x - cur_blob.x)
                                           : (cur_blob.x - prev_blob.x);
    assign dy = (prev_blob.y > cur_blob.y) ? (prev_blob.y - cur_blob.y)
                                           : (cur_blob.y - prev_blob.y);
    assign color_eq  = (prev_blob.color == cur_blob.color);
    assign motion    = (mac_sum < SUM_W'(r_thr_max)) && (mac_sum >= SUM_W'(r_thr_min));
    assign chk_go    = !motion || !r_pend_valid || out_free;
    assign scan_done = (r_i >= r_prev_count);
    assign scan_wrap = (r_j >= r_cur_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_in_data.frame_last) begin
                    n_state = S_THR_MAX;
                end
            end
            S_THR_MAX: n_state = S_THR_MIN;
            S_THR_MIN: n_state = S_START;
            S_START:   n_state = S_SCAN;
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_FINISH;
                end else if (!scan_wrap) begin
                    n_state = S_READ;
                end
            end
            S_READ:    n_state = color_eq ? S_SQY : S_SCAN;
            S_SQY:     n_state = S_CHECK;
            S_CHECK: begin
                if (chk_go) begin
                    n_state = S_SCAN;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        mac_ctl     = '0;
        mac_operand = dx;
        cap_thr_max = 1'b0;
        cap_thr_min = 1'b0;
        do_wrap     = 1'b0;
        adv_j       = 1'b0;
        load_pend   = 1'b0;
        push_mid    = 1'b0;
        finish_go   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_THR_MAX: begin
                mac_ctl.en  = 1'b1;
                mac_operand = COORD_W'(r_max) + COORD_W'(1);
            end
            S_THR_MIN: begin
                mac_ctl.en  = 1'b1;
                mac_operand = COORD_W'(r_min) + COORD_W'(1);
                cap_thr_max = 1'b1;
            end
            S_START: begin
                cap_thr_min = 1'b1;
            end
            S_SCAN: begin
                do_wrap = !scan_done && scan_wrap;
            end
            S_READ: begin
                mac_ctl.en  = color_eq;
                mac_operand = dx;
                adv_j       = !color_eq;
            end
            S_SQY: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.acc = 1'b1;
                mac_operand = dy;
            end
            S_CHECK: begin
                adv_j     = chk_go;
                load_pend = chk_go && motion;
                push_mid  = chk_go && motion && r_pend_valid;
            end
            S_FINISH: begin
                finish_go = out_free;
            end
            default: begin
            end
        endcase
    end

    // Output beat selection.
    always_comb begin
        n_out_data = r_pend;
        if (finish_go) begin
            if (r_pend_valid) begin
                n_out_data.last_of_frame = 1'b1;
            end else begin
                n_out_data               = '0;
                n_out_data.overflow      = r_ovf;
                n_out_data.last_of_frame = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max        <= MAX_MATCH_RESET;
            r_min        <= MIN_MOTION_RESET;
            r_cur_count  <= '0;
            r_prev_count <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_ovf        <= 1'b0;
            r_bank_sel   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && (paddr[2] == REG_MAX_MATCH)) begin
                r_max <= pwdata[DIST_W-1:0];
            end
            if (cfg_wr && (paddr[2] == REG_MIN_MOTION)) begin
                r_min <= pwdata[DIST_W-1:0];
            end
            if (store_wr) begin
                r_cur_count <= r_cur_count + CNT_W'(1);
            end
            if (in_fire && i_in_data.has_blob && !store_wr) begin
                r_ovf <= 1'b1;
            end
            if (cap_thr_min) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (do_wrap) begin
                r_i <= r_i + CNT_W'(1);
                r_j <= '0;
            end
            if (adv_j) begin
                r_j <= r_j + CNT_W'(1);
            end
            if (load_pend) begin
                r_pend_valid <= 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (push_mid || finish_go) begin
                r_out_valid <= 1'b1;
            end
            if (finish_go) begin
                r_pend_valid <= 1'b0;
                r_bank_sel   <= !r_bank_sel;
                r_prev_count <= r_cur_count;
                r_cur_count  <= '0;
                r_ovf        <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (cap_thr_max) begin
            r_thr_max <= mac_sum[THR_W-1:0];
        end
        if (cap_thr_min) begin
            r_thr_min <= mac_sum[THR_W-1:0];
        end
        if (load_pend) begin
            r_pend.is_motion     <= 1'b1;
            r_pend.from_x        <= prev_blob.x;
            r_pend.from_y        <= prev_blob.y;
            r_pend.to_x          <= cur_blob.x;
            r_pend.to_y          <= cur_blob.y;
            r_pend.overflow      <= r_ovf;
            r_pend.last_of_frame <= 1'b0;
        end
        if (push_mid || finish_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    // A held-back record never outlives its frame.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_valid)
        else $error("pending record while accepting input");

    // The closing cycle always empties the held-back record.
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_go |=> !r_pend_valid && o_out_valid && o_out_data.last_of_frame)
        else $error("frame close did not deliver a final beat");

    // An end marker is always the final beat of its frame.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_motion) |-> o_out_data.last_of_frame)
        else $error("end marker without last_of_frame");

    // Pairs are only read inside both fill counts.
    a_pair_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ((r_i < r_prev_count) && (r_j < r_cur_count)))
        else $error("pair index beyond stored blobs");

    // The store never counts past its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_count <= CNT_W'(MAX_BLOBS)) && (r_prev_count <= CNT_W'(MAX_BLOBS)))
        else $error("blob count beyond capacity");
`endif

endmodule

// ===== hdl/bfmm_store.sv =====
`timescale 1ns / 1ps
module bfmm_store (
    input  logic                i_clk,
    input  bfmm_pkg::t_store_ctl i_ctl,
    input  bfmm_pkg::t_blob     i_wr_blob,
    output bfmm_pkg::t_blob     o_prev_blob,
    output bfmm_pkg::t_blob     o_cur_blob
);
    import bfmm_pkg::*;

    // Two banks; bank_sel names the one that collects the current frame.
    t_blob r_bank0 [MAX_BLOBS];
    t_blob r_bank1 [MAX_BLOBS];
    t_blob r_prev_q;
    t_blob r_cur_q;

    logic [IDX_W-1:0] rd_addr0;
    logic [IDX_W-1:0] rd_addr1;
    t_blob            rd0;
    t_blob            rd1;

    // Each bank is read at one address: the previous index or the current one.
    assign rd_addr0 = i_ctl.bank_sel ? i_ctl.prev_idx : i_ctl.cur_idx;
    assign rd_addr1 = i_ctl.bank_sel ? i_ctl.cur_idx  : i_ctl.prev_idx;
    assign rd0      = r_bank0[rd_addr0];
    assign rd1      = r_bank1[rd_addr1];

    // Writes go to the current bank only.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !i_ctl.bank_sel) begin
            r_bank0[i_ctl.wr_idx] <= i_wr_blob;
        end
        if (i_ctl.wr_en && i_ctl.bank_sel) begin
            r_bank1[i_ctl.wr_idx] <= i_wr_blob;
        end
    end

    // Registered read data.
    always_ff @(posedge i_clk) begin
        r_prev_q <= i_ctl.bank_sel ? rd0 : rd1;
        r_cur_q  <= i_ctl.bank_sel ? rd1 : rd0;
    end

    assign o_prev_blob = r_prev_q;
    assign o_cur_blob  = r_cur_q;

endmodule

// ===== hdl/bfmm_sq_acc.sv =====
`timescale 1ns / 1ps
module bfmm_sq_acc (
    input  logic                          i_clk,
    input  bfmm_pkg::t_mac_ctl            i_ctl,
    input  logic [bfmm_pkg::COORD_W-1:0]  i_operand,
    output logic [bfmm_pkg::SUM_W-1:0]    o_sum
);
    import bfmm_pkg::*;

    logic [SQ_W-1:0]  sq;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    // Shared squarer with an optional accumulate of the previous result.
    assign sq    = i_operand * i_operand;
    assign n_sum = i_ctl.acc ? (r_sum + SUM_W'(sq)) : SUM_W'(sq);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
